@@ sv/kqsb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the shared-buffer queue core: sizes, word types, status codes,
// controller states and the controller-to-datapath command struct. No dependencies.
package kqsb_pkg;

	localparam int SLOTS   = 256;
	localparam int QUEUES  = 8;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int LINK_W  = SLOT_W + 1;
	localparam int QIDX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int VALUE_W = 32;

	// Null link: one past the last slot.
	localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ENQ = 1'b0,
		MODE_DEQ = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [2:0]                queue_id;
		logic signed [VALUE_W-1:0] value_in;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_out;
		status_t                   status;
	} result_t;

	typedef enum logic {
		KQ_IDLE = 1'b0,
		KQ_DONE = 1'b1
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic exec;    // take the word: access memories, update pointers
		logic finish;  // apply the link read back, present the result
	} dp_ctrl_t;

endpackage

@@ sv/k_queues_shared_buffer_core.sv @@
`timescale 1ns / 1ps
// Top level of the shared-buffer queue core: controller plus datapath.
// Depends on kqsb_pkg, kqsb_ctrl and kqsb_datapath.
//
// Usage:
//   Holds QUEUES FIFO queues as linked lists in one store of SLOTS slots,
//   with a single free list threading the unused slots.
//   Input channel: drive cmd and raise start; the word is taken at a rising
//   edge where start is high and busy is low. cmd.mode selects enqueue of
//   cmd.value_in onto cmd.queue_id, or dequeue from that queue.
//   Output channel: every word yields one result on result, marked by done
//   for exactly one cycle. The receiver cannot stall; sample it on done.
//   Status: ok, full (enqueue dropped) or empty (dequeue from empty queue);
//   value_out is zero unless a dequeue succeeds.
//   Timing: the word is processed in its accept cycle and the result appears
//   in the next cycle; busy holds off a new word until the result is shown.
//   This is set by the link memory: the next free or next queued slot is read
//   when the word is accepted and becomes a pointer when the result is shown.
//   Reset: arst_n clears all queues and chains every slot onto the free
//   list at once (per-slot valid bits stand in for the reset link values);
//   a word may be started as soon as reset is released.
module k_queues_shared_buffer_core
	import kqsb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	dp_ctrl_t ctrl;

	// Sequence each word: exec on accept, finish in the following cycle.
	kqsb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	// Hold the slot store and pointers; produce the result on finish.
	kqsb_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cmd    (cmd),
		.result (result)
	);

endmodule

@@ sv/kqsb_ctrl.sv @@
`timescale 1ns / 1ps
// Controller for the shared-buffer queue core: two-state sequencer that
// issues exec and finish commands. Depends on kqsb_pkg.
module kqsb_ctrl
	import kqsb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output dp_ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			KQ_IDLE: begin
				if (start) begin
					state_d = KQ_DONE;
				end
			end
			KQ_DONE: begin
				state_d = KQ_IDLE;
			end
			default: begin
				state_d = KQ_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		done        = 1'b0;
		ctrl.exec   = 1'b0;
		ctrl.finish = 1'b0;
		case (state_q)
			KQ_IDLE: begin
				ctrl.exec = start;
			end
			KQ_DONE: begin
				busy        = 1'b1;
				done        = 1'b1;
				ctrl.finish = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	a_finish_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |-> $past(ctrl.exec))
		else $error("finish without a preceding exec");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("controller stayed busy after a result");

endmodule

@@ sv/kqsb_datapath.sv @@
`timescale 1ns / 1ps
// Datapath for the shared-buffer queue core: slot data and link memories,
// free-list head, per-queue head and tail pointers. Depends on kqsb_pkg.
module kqsb_datapath
	import kqsb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dp_ctrl_t ctrl,
	input  cmd_t     cmd,
	output result_t  result
);

	logic signed [VALUE_W-1:0] data_mem [SLOTS];
	logic [LINK_W-1:0]         link_mem [SLOTS];
	logic [SLOTS-1:0]          link_vld_q;

	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] head_q [QUEUES];
	logic [LINK_W-1:0] tail_q [QUEUES];

	logic [LINK_W-1:0]         link_rd_q;
	logic                      link_vld_rd_q;
	logic signed [VALUE_W-1:0] data_rd_q;
	logic [SLOT_W-1:0]         addr_q;
	logic                      enq_q;
	logic                      deq_q;
	logic                      deq_last_q;
	logic [QIDX_W-1:0]         qi_q;
	status_t                   status_q;

	logic [QIDX_W-1:0] qi;
	logic              q_ok;
	logic [LINK_W-1:0] hd;
	logic [LINK_W-1:0] tl;
	logic              hd_ok;
	logic              tl_ok;
	logic              fh_ok;
	logic              enq_go;
	logic              deq_go;
	logic [SLOT_W-1:0] mem_addr;
	logic              link_we;
	logic [SLOT_W-1:0] link_wa;
	logic [LINK_W-1:0] link_wd;
	logic [LINK_W-1:0] nxt;
	logic              nxt_ok;

	assign qi     = cmd.queue_id[QIDX_W-1:0];
	assign q_ok   = 32'(cmd.queue_id) < QUEUES;
	assign hd     = head_q[qi];
	assign tl     = tail_q[qi];
	assign hd_ok  = hd < NIL;
	assign tl_ok  = tl < NIL;
	assign fh_ok  = free_head_q < NIL;
	assign enq_go = ctrl.exec && (cmd.mode == MODE_ENQ) && q_ok && fh_ok;
	assign deq_go = ctrl.exec && (cmd.mode == MODE_DEQ) && q_ok && hd_ok;

	assign mem_addr = enq_go ? free_head_q[SLOT_W-1:0] : hd[SLOT_W-1:0];

	// Enqueue links the old tail to the new slot; dequeue pushes the slot
	// onto the free list. The new tail's own link is overwritten before use.
	always_comb begin
		link_we = 1'b0;
		link_wa = hd[SLOT_W-1:0];
		link_wd = free_head_q;
		if (enq_go && tl_ok) begin
			link_we = 1'b1;
			link_wa = tl[SLOT_W-1:0];
			link_wd = free_head_q;
		end else if (deq_go) begin
			link_we = 1'b1;
			link_wa = hd[SLOT_W-1:0];
			link_wd = free_head_q;
		end
	end

	// Read before write on the same address.
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		link_rd_q <= link_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (enq_go) begin
			data_mem[mem_addr] <= cmd.value_in;
		end
		data_rd_q <= data_mem[mem_addr];
	end

	// An unwritten link holds its reset chain value, slot i to i+1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
		end else if (link_we) begin
			link_vld_q[link_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			link_vld_rd_q <= link_vld_q[mem_addr];
			addr_q        <= mem_addr;
			qi_q          <= qi;
			deq_last_q    <= (hd == tl);
			if (enq_go || deq_go) begin
				status_q <= ST_OK;
			end else if (cmd.mode == MODE_DEQ) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_FULL;
			end
		end
	end

	assign nxt    = link_vld_rd_q ? link_rd_q : ({1'b0, addr_q} + LINK_W'(1));
	assign nxt_ok = nxt < NIL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enq_q       <= 1'b0;
			deq_q       <= 1'b0;
			free_head_q <= '0;
			for (int i = 0; i < QUEUES; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
		end else begin
			if (ctrl.exec) begin
				enq_q <= enq_go;
				deq_q <= deq_go;
			end
			if (enq_go) begin
				if (!tl_ok) begin
					head_q[qi] <= free_head_q;
				end
				tail_q[qi] <= free_head_q;
			end
			if (deq_go) begin
				free_head_q <= hd;
				if (hd == tl) begin
					head_q[qi] <= NIL;
					tail_q[qi] <= NIL;
				end
			end
			if (ctrl.finish) begin
				if (enq_q) begin
					free_head_q <= nxt_ok ? nxt : NIL;
				end
				if (deq_q && !deq_last_q) begin
					head_q[qi_q] <= nxt_ok ? nxt : NIL;
					if (!nxt_ok) begin
						tail_q[qi_q] <= NIL;
					end
				end
			end
		end
	end

	assign result.value_out = deq_q ? data_rd_q : '0;
	assign result.status    = status_q;

	a_head_tail_pair: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.exec |-> (hd_ok == tl_ok))
		else $error("queue head and tail disagree on emptiness");

	a_deq_frees_slot: assert property (@(posedge clk) disable iff (!arst_n)
		deq_go |=> fh_ok)
		else $error("free list empty right after a dequeue");

	a_status_matches_op: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |-> ((status_q == ST_OK) == (enq_q || deq_q)))
		else $error("status does not match the operation performed");

endmodule

@@ sim/tb_k_queues_shared_buffer_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for k_queues_shared_buffer_core: random enqueue/dequeue words against a
// linked-list mirror of the slot store. Depends on kqsb_pkg and the core RTL.
module tb_k_queues_shared_buffer_core;
	import kqsb_pkg::*;

	localparam int RANDOM_WORDS = 1250;
	localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES = 8;     // settle time after the last answer

	// Random stimulus walks through these phases over and over, so the free list
	// is exhausted and refilled and long per-queue chains build up.
	typedef enum int {
		PH_FILL,
		PH_MIX_A,
		PH_DRAIN,
		PH_MIX_B
	} phase_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	result_t result;

	cmd_t    cmd_backlog[$];      // words waiting to be driven
	result_t pending_answers[$];  // predicted answers, oldest first
	int      fail_count  = 0;
	int      idle_cycles = 0;

	// Count-only view of the buffer at generation time, used to steer phases.
	int gen_fill[8];
	int gen_used = 0;

	// Linked-list mirror of the slot store, updated as words are accepted.
	logic signed [VALUE_W-1:0] slot_value[SLOTS];
	logic [LINK_W-1:0]         slot_next[SLOTS];
	logic [LINK_W-1:0]         free_slot;
	logic [LINK_W-1:0]         q_first[8];
	logic [LINK_W-1:0]         q_last[8];

	int gap_left   = 0;
	int burst_left = 0;

	k_queues_shared_buffer_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Work out the answer to one accepted word and advance the mirror.
	function automatic result_t buffer_answer(cmd_t w);
		result_t r;
		int      s;
		r.value_out = '0;
		r.status    = ST_OK;
		if (w.mode == MODE_ENQ) begin
			if (w.queue_id >= QUEUES || free_slot >= SLOTS) begin
				r.status = ST_FULL;
			end else begin
				// pop the free head, store the value, hang the slot off the tail
				s = free_slot;
				free_slot = (slot_next[s] < SLOTS) ? slot_next[s] : NIL;
				slot_value[s] = w.value_in;
				slot_next[s]  = NIL;
				if (q_last[w.queue_id] < SLOTS)
					slot_next[q_last[w.queue_id]] = LINK_W'(s);
				else
					q_first[w.queue_id] = LINK_W'(s);
				q_last[w.queue_id] = LINK_W'(s);
			end
		end else begin
			if (w.queue_id >= QUEUES || q_first[w.queue_id] >= SLOTS) begin
				r.status = ST_EMPTY;
			end else begin
				// unlink the head slot and push it onto the front of the free list
				s = q_first[w.queue_id];
				if (s == q_last[w.queue_id]) begin
					q_first[w.queue_id] = NIL;
					q_last[w.queue_id]  = NIL;
				end else begin
					q_first[w.queue_id] = (slot_next[s] < SLOTS) ? slot_next[s] : NIL;
					if (slot_next[s] >= SLOTS)
						q_last[w.queue_id] = NIL;
				end
				slot_next[s] = free_slot;
				free_slot    = LINK_W'(s);
				r.value_out  = slot_value[s];
			end
		end
		return r;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	// Queue one word for the driver and track occupancy for phase steering.
	task automatic add_word(mode_t m, logic [2:0] q, logic signed [VALUE_W-1:0] v);
		cmd_t w;
		w.mode     = m;
		w.queue_id = q;
		w.value_in = v;
		cmd_backlog.push_back(w);
		if (m == MODE_ENQ) begin
			if (q < QUEUES && gen_used < SLOTS) begin
				gen_fill[q]++;
				gen_used++;
			end
		end else if (q < QUEUES && gen_fill[q] > 0) begin
			gen_fill[q]--;
			gen_used--;
		end
	endtask

	task automatic report_fail(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] ERROR: %s", $realtime, what);
	endtask

	// Driver: hold the word while busy, otherwise issue the next one from the
	// backlog in bursts separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			gap_left   <= 0;
			burst_left <= $urandom_range(1, 12);
		end else if (!(start && busy)) begin
			if (gap_left > 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_backlog.size() > 0) begin
				start <= 1'b1;
				cmd   <= cmd_backlog.pop_front();
				if (burst_left <= 1) begin
					// end of burst: draw a gap, now and then none at all
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
					burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
					                                          : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: predict on every accepted word, then check any answer on done.
	// Predict first so an answer in the accept cycle would still find its entry.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_value[i] = '0;
				slot_next[i]  = (i == SLOTS - 1) ? NIL : LINK_W'(i + 1);
			end
			for (int i = 0; i < 8; i++) begin
				q_first[i] = NIL;
				q_last[i]  = NIL;
			end
			free_slot = '0;
		end else begin
			if (start && !busy)
				pending_answers.push_back(buffer_answer(cmd));
			if (done) begin
				if (pending_answers.size() == 0) begin
					report_fail($sformatf("unexpected answer value_out=%0d status=%0d",
						result.value_out, result.status));
				end else begin
					want = pending_answers.pop_front();
					if (result.value_out !== want.value_out || result.status !== want.status)
						report_fail($sformatf("expected value_out=%0d status=%0d, got value_out=%0d status=%0d",
							want.value_out, want.status, result.value_out, result.status));
				end
			end
		end
	end

	// Watchdog: any handshake on either side counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		phase_t     phase;
		int         rand_words;
		int         phase_words;
		int         tail_words;
		int         mix_len;
		int         enq_pct;
		logic [2:0] fav;
		logic [2:0] q;
		mode_t      m;

		foreach (gen_fill[i])
			gen_fill[i] = 0;

		// Directed: dequeue from an empty queue, one word per queue carrying the
		// value extremes, drain every queue (single-entry head equals tail),
		// then confirm queues 0 and 7 report empty and order is kept on queue 2.
		add_word(MODE_DEQ, 3'd0, 32'sd0);
		add_word(MODE_ENQ, 3'd0, 32'sh8000_0000);
		add_word(MODE_ENQ, 3'd1, 32'sh7fff_ffff);
		add_word(MODE_ENQ, 3'd2, 32'sd0);
		add_word(MODE_ENQ, 3'd3, -32'sd1);
		add_word(MODE_ENQ, 3'd4, 32'sh5555_5555);
		add_word(MODE_ENQ, 3'd5, 32'shaaaa_aaaa);
		add_word(MODE_ENQ, 3'd6, 32'sd1);
		add_word(MODE_ENQ, 3'd7, 32'sd7);
		for (int i = 0; i < 8; i++)
			add_word(MODE_DEQ, 3'(i), 32'sh7fff_ffff);
		add_word(MODE_DEQ, 3'd0, 32'sd0);
		add_word(MODE_DEQ, 3'd7, 32'sd0);
		add_word(MODE_ENQ, 3'd2, 32'sd100);
		add_word(MODE_ENQ, 3'd2, -32'sd200);
		add_word(MODE_DEQ, 3'd2, 32'sd0);
		add_word(MODE_DEQ, 3'd2, 32'sd0);

		// Random: fill until the free list runs dry, mix, drain to empty, mix.
		rand_words  = 0;
		phase_words = 0;
		tail_words  = 0;
		phase       = PH_FILL;
		fav         = 3'($urandom_range(0, 7));
		mix_len     = $urandom_range(20, 80);
		while (rand_words < RANDOM_WORDS) begin
			case (phase)
				PH_FILL:  enq_pct = 90;
				PH_DRAIN: enq_pct = 10;
				default:  enq_pct = 50;
			endcase
			m = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
			q = $urandom_range(0, 1) ? fav : 3'($urandom_range(0, 7));
			// steer most drain dequeues toward a queue that still holds data
			if (phase == PH_DRAIN && m == MODE_DEQ && $urandom_range(0, 3) != 0) begin
				for (int k = 0; k < 8 && gen_fill[q] == 0; k++)
					q = q + 3'd1;
			end
			add_word(m, q, pick_value());
			rand_words++;
			phase_words++;
			case (phase)
				PH_FILL: begin
					if (gen_used == SLOTS)
						tail_words++;
					if (tail_words >= 10) begin
						phase = PH_MIX_A;
						phase_words = 0;
					end
				end
				PH_MIX_A: begin
					if (phase_words >= mix_len) begin
						phase = PH_DRAIN;
						tail_words = 0;
					end
				end
				PH_DRAIN: begin
					if (gen_used == 0)
						tail_words++;
					if (tail_words >= 10) begin
						phase = PH_MIX_B;
						phase_words = 0;
						mix_len = $urandom_range(20, 80);
					end
				end
				default: begin
					if (phase_words >= mix_len) begin
						phase = PH_FILL;
						tail_words = 0;
						fav = 3'($urandom_range(0, 7));
					end
				end
			endcase
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every word is taken, every answer is in, then settle.
		while (cmd_backlog.size() != 0 || start)
			@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_answers.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/kqsb_pkg.sv
sv/kqsb_ctrl.sv
sv/kqsb_datapath.sv
sv/k_queues_shared_buffer_core.sv
sim/tb_k_queues_shared_buffer_core.sv
